// File: rtl/bgc_pkg.sv
package bgc_pkg;

    localparam int unsigned CFG_W   = 16;
    localparam int unsigned TIME_W  = 32;
    localparam int unsigned IDX_W   = 8;
    localparam int unsigned IN_TW   = 40;
    localparam int unsigned OUT_TW  = 8;

    localparam logic [CFG_W-1:0] HOLD_CONFIRM_RST = 16'd400;
    localparam logic [CFG_W-1:0] DOUBLE_GAP_RST   = 16'd300;
    localparam logic [CFG_W-1:0] MAINT_FIRST_RST  = 16'd5000;
    localparam logic [CFG_W-1:0] MAINT_SECOND_RST = 16'd10000;

    typedef enum logic [IDX_W-1:0] {
        REG_HOLD_CONFIRM = 8'd0,
        REG_DOUBLE_GAP   = 8'd1,
        REG_MAINT_FIRST  = 8'd2,
        REG_MAINT_SECOND = 8'd3
    } t_reg_idx;

    typedef enum logic [2:0] {
        PH_IDLE    = 3'd0,
        PH_PRESS   = 3'd1,
        PH_HOLD    = 3'd2,
        PH_TAPWAIT = 3'd3,
        PH_SECOND  = 3'd4,
        PH_MAINT   = 3'd5
    } t_phase;

    typedef enum logic [2:0] {
        EV_NONE         = 3'd0,
        EV_HOLD_START   = 3'd1,
        EV_HOLD_END     = 3'd2,
        EV_SINGLE       = 3'd3,
        EV_DOUBLE       = 3'd4,
        EV_MAINT_FIRST  = 3'd5,
        EV_MAINT_SECOND = 3'd6
    } t_event;

    typedef struct packed {
        logic [CFG_W-1:0] hold_confirm_time;
        logic [CFG_W-1:0] double_tap_gap;
        logic [CFG_W-1:0] maint_first_time;
        logic [CFG_W-1:0] maint_second_time;
    } t_cfg;

    typedef struct packed {
        t_phase phase;
        logic   first_done;
        logic   second_done;
    } t_status;

endpackage

// File: rtl/bgc_cfg.sv
module bgc_cfg
    import bgc_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_we,
    input  logic [IDX_W-1:0] i_index,
    input  logic [CFG_W-1:0] i_data,
    output t_cfg             o_cfg
);

    t_cfg r_cfg;
    t_cfg n_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_we) begin
            unique case (i_index)
                REG_HOLD_CONFIRM: n_cfg.hold_confirm_time = i_data;
                REG_DOUBLE_GAP:   n_cfg.double_tap_gap    = i_data;
                REG_MAINT_FIRST:  n_cfg.maint_first_time  = i_data;
                REG_MAINT_SECOND: n_cfg.maint_second_time = i_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.hold_confirm_time <= HOLD_CONFIRM_RST;
            r_cfg.double_tap_gap    <= DOUBLE_GAP_RST;
            r_cfg.maint_first_time  <= MAINT_FIRST_RST;
            r_cfg.maint_second_time <= MAINT_SECOND_RST;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

// File: rtl/bgc_core.sv
module bgc_core
    import bgc_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_step,
    input  logic              i_level,
    input  logic [TIME_W-1:0] i_time,
    input  t_cfg              i_cfg,
    output t_event            o_event,
    output t_status           o_status
);

    t_phase            r_phase, n_phase;
    logic              r_prev;
    logic [TIME_W-1:0] r_edge, n_edge;
    logic              r_first_done, n_first_done;
    logic              r_second_done, n_second_done;
    t_event            n_event;

    logic              rise, fall;
    logic [TIME_W-1:0] held;
    logic              hold_hit, gap_hit, first_hit, second_hit;

    assign rise = i_level & ~r_prev;
    assign fall = ~i_level & r_prev;
    assign held = i_time - r_edge;

    assign hold_hit   = held >= {{(TIME_W-CFG_W){1'b0}}, i_cfg.hold_confirm_time};
    assign gap_hit    = held >= {{(TIME_W-CFG_W){1'b0}}, i_cfg.double_tap_gap};
    assign first_hit  = held >= {{(TIME_W-CFG_W){1'b0}}, i_cfg.maint_first_time};
    assign second_hit = held >= {{(TIME_W-CFG_W){1'b0}}, i_cfg.maint_second_time};

    always_comb begin
        n_phase       = r_phase;
        n_edge        = r_edge;
        n_first_done  = r_first_done;
        n_second_done = r_second_done;
        n_event       = EV_NONE;
        unique case (r_phase)
            PH_IDLE: begin
                if (rise) begin
                    n_phase = PH_PRESS;
                    n_edge  = i_time;
                end
            end
            PH_PRESS: begin
                if (fall) begin
                    n_phase = PH_TAPWAIT;
                    n_edge  = i_time;
                end else if (hold_hit) begin
                    n_phase = PH_HOLD;
                    n_edge  = i_time;
                    n_event = EV_HOLD_START;
                end
            end
            PH_HOLD: begin
                if (fall) begin
                    n_phase = PH_IDLE;
                    n_event = EV_HOLD_END;
                end
            end
            PH_TAPWAIT: begin
                if (rise) begin
                    n_phase = PH_SECOND;
                    n_edge  = i_time;
                end else if (gap_hit) begin
                    n_phase = PH_IDLE;
                    n_event = EV_SINGLE;
                end
            end
            PH_SECOND: begin
                if (fall) begin
                    n_phase = PH_IDLE;
                    n_event = EV_DOUBLE;
                end else if (hold_hit) begin
                    n_phase       = PH_MAINT;
                    n_edge        = i_time;
                    n_first_done  = 1'b0;
                    n_second_done = 1'b0;
                end
            end
            PH_MAINT: begin
                // second threshold wins when both are reached
                if (fall) begin
                    n_phase = PH_IDLE;
                end else if (!r_second_done && second_hit) begin
                    n_second_done = 1'b1;
                    n_event       = EV_MAINT_SECOND;
                end else if (!r_first_done && first_hit) begin
                    n_first_done = 1'b1;
                    n_event      = EV_MAINT_FIRST;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase       <= PH_IDLE;
            r_prev        <= 1'b0;
            r_edge        <= '0;
            r_first_done  <= 1'b0;
            r_second_done <= 1'b0;
        end else if (i_step) begin
            r_phase       <= n_phase;
            r_prev        <= i_level;
            r_edge        <= n_edge;
            r_first_done  <= n_first_done;
            r_second_done <= n_second_done;
        end
    end

    assign o_event              = n_event;
    assign o_status.phase       = r_phase;
    assign o_status.first_done  = r_first_done;
    assign o_status.second_done = r_second_done;

endmodule

// File: rtl/button_gesture_classifier.sv
// Button gesture classifier. Each input word is one button sample with its
// millisecond timestamp; each yields exactly one output word carrying the
// gesture event (none, hold start/end, single tap, double tap, maintenance
// first/second). One word per clock is sustained unless m_axis_tready stalls the
// output: a sample passes the input register, is classified by the phase machine
// and lands in the output register. s_axis_tready stays high while the input
// register is empty or the output register moves on. The four 16-bit thresholds
// are written via the cfg channel (always ready), by the user only while idle (unenforced).
module button_gesture_classifier
    import bgc_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              s_axis_tvalid,
    output logic              s_axis_tready,
    input  logic [IN_TW-1:0]  s_axis_tdata,   // [0] button_down, [32:1] time_ms, [39:33] zero
    output logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    output logic [OUT_TW-1:0] m_axis_tdata,   // [2:0] gesture_event, [7:3] zero
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic [IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_W-1:0]  i_cfg_data
);

    logic              r_in_valid;
    logic              r_in_level;
    logic [TIME_W-1:0] r_in_time;
    logic              r_out_valid;
    t_event            r_out_event;

    logic    advance;
    logic    in_take;
    t_cfg    cfg;
    t_event  step_event;
    t_status status;

    assign o_cfg_ready = 1'b1;

    bgc_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_we    (i_cfg_valid),
        .i_index (i_cfg_index),
        .i_data  (i_cfg_data),
        .o_cfg   (cfg)
    );

    assign advance       = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || advance;
    assign in_take       = s_axis_tvalid && s_axis_tready;

    bgc_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (advance),
        .i_level  (r_in_level),
        .i_time   (r_in_time),
        .i_cfg    (cfg),
        .o_event  (step_event),
        .o_status (status)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_take) begin
                r_in_valid <= 1'b1;
            end else if (advance) begin
                r_in_valid <= 1'b0;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in_level <= s_axis_tdata[0];
            r_in_time  <= s_axis_tdata[TIME_W:1];
        end
        if (advance) begin
            r_out_event <= step_event;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {{(OUT_TW-3){1'b0}}, r_out_event};

`ifndef SYNTHESIS
    a_hold_end_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance && step_event == EV_HOLD_END |=> status.phase == PH_IDLE)
        else $error("hold end did not return to idle");

    a_maint_once: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance && step_event == EV_MAINT_SECOND |=> status.second_done)
        else $error("maintenance second event not marked done");

    a_maint_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance && (step_event == EV_MAINT_FIRST || step_event == EV_MAINT_SECOND)
        |-> status.phase == PH_MAINT)
        else $error("maintenance event outside maintenance hold");

    a_in_kept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && !advance |=> r_in_valid && $stable(r_in_time))
        else $error("pending input word lost");
`endif

endmodule

// File: tb/tb_top.sv
module tb_top;
    import bgc_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned CYCLE_LIMIT = 400000;
    localparam int unsigned DRAIN_CYCLES = 6;
    localparam logic [IDX_W-1:0] REG_IDX_UNUSED = 8'hFF;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              s_axis_tvalid = 1'b0;
    logic              s_axis_tready;
    logic [IN_TW-1:0]  s_axis_tdata = '0;
    logic              m_axis_tvalid;
    logic              m_axis_tready = 1'b0;
    logic [OUT_TW-1:0] m_axis_tdata;
    logic              i_cfg_valid = 1'b0;
    logic              o_cfg_ready;
    logic [IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_W-1:0]  i_cfg_data = '0;

    button_gesture_classifier dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    // gesture tracker state and thresholds
    logic [CFG_W-1:0]  thr_hold = HOLD_CONFIRM_RST;
    logic [CFG_W-1:0]  thr_gap = DOUBLE_GAP_RST;
    logic [CFG_W-1:0]  thr_maint1 = MAINT_FIRST_RST;
    logic [CFG_W-1:0]  thr_maint2 = MAINT_SECOND_RST;
    t_phase            trk_phase = PH_IDLE;
    logic              trk_level = 1'b0;
    logic [TIME_W-1:0] trk_edge = '0;
    logic              trk_first_done = 1'b0;
    logic              trk_second_done = 1'b0;

    t_event            pending_events[$];
    int unsigned       error_count = 0;
    int unsigned       samples_sent = 0;
    int unsigned       cycle_count = 0;
    int unsigned       send_idle_pct = 0;
    int unsigned       recv_idle_pct = 0;
    logic [TIME_W-1:0] sample_time = '0;
    int unsigned       sample_step = 1;

    function automatic t_event classify_sample(input logic level, input logic [TIME_W-1:0] now);
        logic              rise;
        logic              fall;
        logic [TIME_W-1:0] held;
        t_event            ev;
        rise = level && !trk_level;
        fall = !level && trk_level;
        held = now - trk_edge;
        ev = EV_NONE;
        trk_level = level;
        case (trk_phase)
            PH_IDLE: begin
                if (rise) begin
                    trk_phase = PH_PRESS;
                    trk_edge = now;
                end
            end
            PH_PRESS: begin
                if (fall) begin
                    trk_phase = PH_TAPWAIT;
                    trk_edge = now;
                end else if (held >= {16'd0, thr_hold}) begin
                    trk_phase = PH_HOLD;
                    trk_edge = now;
                    ev = EV_HOLD_START;
                end
            end
            PH_HOLD: begin
                if (fall) begin
                    trk_phase = PH_IDLE;
                    ev = EV_HOLD_END;
                end
            end
            PH_TAPWAIT: begin
                if (rise) begin
                    trk_phase = PH_SECOND;
                    trk_edge = now;
                end else if (held >= {16'd0, thr_gap}) begin
                    trk_phase = PH_IDLE;
                    ev = EV_SINGLE;
                end
            end
            PH_SECOND: begin
                if (fall) begin
                    trk_phase = PH_IDLE;
                    ev = EV_DOUBLE;
                end else if (held >= {16'd0, thr_hold}) begin
                    trk_phase = PH_MAINT;
                    trk_edge = now;
                    trk_first_done = 1'b0;
                    trk_second_done = 1'b0;
                end
            end
            PH_MAINT: begin
                if (fall) begin
                    trk_phase = PH_IDLE;
                end else if (!trk_second_done && held >= {16'd0, thr_maint2}) begin
                    trk_second_done = 1'b1;
                    ev = EV_MAINT_SECOND;
                end else if (!trk_first_done && held >= {16'd0, thr_maint1}) begin
                    trk_first_done = 1'b1;
                    ev = EV_MAINT_FIRST;
                end
            end
            default: ;
        endcase
        return ev;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("ERROR @%0d: %s", cycle_count, msg);
        error_count++;
    endtask

    // entered and left at a falling edge
    task automatic send_sample(input logic level, input logic [TIME_W-1:0] now);
        while ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {7'd0, now, level};
        do @(posedge i_clk); while (!s_axis_tready);
        pending_events.push_back(classify_sample(level, now));
        samples_sent++;
        @(negedge i_clk);
    endtask

    task automatic send_at(input logic level, input int unsigned delta);
        sample_time = sample_time + delta;
        send_sample(level, sample_time);
    endtask

    task automatic wait_results();
        s_axis_tvalid <= 1'b0;
        while (pending_events.size() != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            REG_HOLD_CONFIRM: thr_hold = val;
            REG_DOUBLE_GAP:   thr_gap = val;
            REG_MAINT_FIRST:  thr_maint1 = val;
            REG_MAINT_SECOND: thr_maint2 = val;
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
        @(negedge i_clk);
    endtask

    task automatic write_all(input logic [CFG_W-1:0] hold, input logic [CFG_W-1:0] gap,
                             input logic [CFG_W-1:0] m1, input logic [CFG_W-1:0] m2);
        wait_results();
        write_reg(REG_HOLD_CONFIRM, hold);
        write_reg(REG_DOUBLE_GAP, gap);
        write_reg(REG_MAINT_FIRST, m1);
        write_reg(REG_MAINT_SECOND, m2);
    endtask

    function automatic int unsigned below(input int unsigned th);
        return (th == 0) ? 0 : $urandom_range(th - 1, 0);
    endfunction

    function automatic int unsigned above(input int unsigned th);
        return th + $urandom_range(th / 2 + 4, 0);
    endfunction

    // keep one level for at least dur ms, sampling at random steps
    task automatic hold_level(input logic level, input int unsigned dur);
        logic [TIME_W-1:0] start;
        start = sample_time;
        do begin
            send_at(level, $urandom_range(sample_step, 0));
        end while (sample_time - start < dur);
    endtask

    task automatic random_gesture();
        int unsigned lo;
        int unsigned hi;
        int unsigned extra;
        lo = 32'((thr_maint1 < thr_maint2) ? thr_maint1 : thr_maint2);
        hi = 32'((thr_maint1 < thr_maint2) ? thr_maint2 : thr_maint1);
        case ($urandom_range(9))
            0, 1: begin
                hold_level(1'b1, below(32'(thr_hold)));
                hold_level(1'b0, above(32'(thr_gap)));
            end
            2, 3: begin
                hold_level(1'b1, below(32'(thr_hold)));
                hold_level(1'b0, below(32'(thr_gap)));
                hold_level(1'b1, below(32'(thr_hold)));
                hold_level(1'b0, above(32'(thr_gap)));
            end
            4: begin
                hold_level(1'b1, above(32'(thr_hold)));
                hold_level(1'b0, above(32'(thr_gap)));
            end
            5, 6: begin
                case ($urandom_range(2))
                    0: extra = below(lo);
                    1: extra = lo + $urandom_range(hi - lo, 0);
                    default: extra = above(hi);
                endcase
                hold_level(1'b1, below(32'(thr_hold)));
                hold_level(1'b0, below(32'(thr_gap)));
                hold_level(1'b1, 32'(thr_hold) + extra);
                hold_level(1'b0, above(32'(thr_gap)));
            end
            7: begin
                hold_level(1'b1, 32'(thr_hold));
                hold_level(1'b0, 32'(thr_gap));
            end
            default: begin
                // noise: random levels and time jumps, backwards included
                repeat ($urandom_range(4, 1)) begin
                    if ($urandom_range(1))
                        sample_time = $urandom();
                    send_at(1'($urandom_range(1)), $urandom_range(3 * sample_step, 0));
                end
            end
        endcase
    endtask

    task automatic random_gestures(input int unsigned n, input bit pause_midway);
        int unsigned first;
        bit          paused;
        first = samples_sent;
        paused = 1'b0;
        sample_step = 32'((thr_hold < thr_gap) ? thr_hold : thr_gap) / 4 + 1;
        while (samples_sent - first < n) begin
            random_gesture();
            if (pause_midway && !paused && samples_sent - first >= n / 2) begin
                wait_results();
                paused = 1'b1;
            end
        end
    endtask

    task automatic test_unused_index();
        // must leave every threshold at its reset value
        write_reg(REG_IDX_UNUSED, 16'h0000);
    endtask

    task automatic test_default_gestures();
        sample_time = '0;
        send_at(1'b0, 0);
        send_at(1'b1, 10);
        send_at(1'b0, 50);
        send_at(1'b0, 300);      // single tap
        send_at(1'b1, 5);
        send_at(1'b0, 5);
        send_at(1'b1, 5);
        send_at(1'b0, 5);        // double tap
        send_at(1'b1, 5);
        send_at(1'b1, 400);      // hold start
        send_at(1'b0, 7);        // hold end
        send_at(1'b1, 1);
        send_at(1'b0, 1);
        send_at(1'b1, 1);
        send_at(1'b1, 400);      // maintenance hold entered
        send_at(1'b1, 12000);    // both thresholds passed: second fires first
        send_at(1'b1, 0);
        send_at(1'b1, 0);
        send_at(1'b0, 1);        // release ends maintenance silently
    endtask

    task automatic test_zero_thresholds();
        write_all(16'd0, 16'd0, 16'd0, 16'd0);
        send_at(1'b1, 1);
        send_at(1'b1, 0);
        send_at(1'b0, 0);
        send_at(1'b1, 1);
        send_at(1'b0, 0);
        send_at(1'b0, 0);
    endtask

    task automatic test_max_thresholds();
        write_all(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        sample_time = 32'hFFFF_FFFF;
        send_at(1'b1, 0);
        send_at(1'b1, 65534);    // one short, across the time wrap
        send_at(1'b1, 1);
        send_at(1'b0, 3);
    endtask

    task automatic test_random_slow_receiver();
        write_all(16'($urandom_range(80, 10)), 16'($urandom_range(80, 10)),
                  16'($urandom_range(300, 50)), 16'($urandom_range(300, 50)));
        send_idle_pct = 17;
        recv_idle_pct = 82;
        random_gestures(580, 1'b0);
    endtask

    task automatic test_random_slow_sender();
        write_all(16'($urandom_range(120, 5)), 16'($urandom_range(120, 5)),
                  16'($urandom_range(400, 0)), 16'($urandom_range(400, 0)));
        send_idle_pct = 82;
        recv_idle_pct = 17;
        random_gestures(580, 1'b1);
    endtask

    task automatic test_random_full_rate();
        write_all(16'($urandom_range(40, 0)), 16'($urandom_range(40, 0)),
                  16'($urandom_range(200, 0)), 16'($urandom_range(200, 0)));
        send_idle_pct = 0;
        recv_idle_pct = 0;
        random_gestures(580, 1'b0);
    endtask

    always @(negedge i_clk) begin
        m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    always @(posedge i_clk) begin
        t_event want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pending_events.size() == 0) begin
                report_mismatch($sformatf("unexpected word, event %0d", m_axis_tdata[2:0]));
            end else begin
                want = pending_events.pop_front();
                if (m_axis_tdata[2:0] !== want)
                    report_mismatch($sformatf("event %0d, expected %0d",
                                              m_axis_tdata[2:0], want));
            end
        end
    end

    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("Simulation FAILED");
        $finish;
    end

    initial begin
        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        test_unused_index();
        test_default_gestures();
        test_zero_thresholds();
        test_max_thresholds();
        test_random_slow_receiver();
        test_random_slow_sender();
        test_random_full_rate();
        wait_results();
        if (error_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
